// File: hdl/lr4lp_pkg.sv
// Shared constants and register codes for the fourth-order lowpass filter.
`timescale 1ns / 1ps

package lr4lp_pkg;

    localparam int CHANNELS_DEF    = 8;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int CHAN_BITS       = 3;
    localparam int COEF_BITS       = 32;
    localparam int COEF_FRAC       = 28;
    localparam int HIST_BITS       = 32;
    localparam int CFG_IDX_BITS    = 3;
    localparam int OUT_DEPTH       = 4;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_NUMER_GAIN    = 3'd0,
        REG_FB_COEF_ONE   = 3'd1,
        REG_FB_COEF_TWO   = 3'd2,
        REG_FB_COEF_THREE = 3'd3,
        REG_FB_COEF_FOUR  = 3'd4
    } cfg_reg_t;

endpackage

// File: hdl/lr4lp_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps

module lr4lp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/lr4_lowpass_iir_multichannel.sv
// Top level: multichannel fourth-order lowpass IIR, direct form I, history in RAM.
//
//  channel  direction  payload (lowest bit up)
//  s_axis   in         tdata: chan[2:0], sample_in[SAMPLE_BITS-1:0], zero pad
//  m_axis   out        tdata: chan_out[2:0], sample_out[SAMPLE_BITS-1:0], zero pad
//  cfg      in         cfg_we, cfg_index, cfg_data (coefficient registers)
//
// A new word is taken only while stage 0 is empty: the two shared multipliers take
// two passes per word. Steps from input accept to output valid: history RAM read, tap sum,
// two multiply passes, accumulate, round and write back, output queue write.
// A word for a channel still in the pipeline waits until its history is written back.
// Reset clears the per-channel valid bits at once; no clearing pass.
// A 4-word output queue absorbs m_axis stalls; input also stalls when it is committed full.
`timescale 1ns / 1ps

module lr4_lowpass_iir_multichannel #(
    parameter int CHANNELS    = lr4lp_pkg::CHANNELS_DEF,
    parameter int SAMPLE_BITS = lr4lp_pkg::SAMPLE_BITS_DEF,
    localparam int TDATA_BITS = ((lr4lp_pkg::CHAN_BITS + SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [lr4lp_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [lr4lp_pkg::COEF_BITS-1:0]     cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [TDATA_BITS-1:0]               s_axis_tdata,  // chan, sample_in
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [TDATA_BITS-1:0]               m_axis_tdata   // chan_out, sample_out
);

    localparam int CW      = lr4lp_pkg::CHAN_BITS;
    localparam int SB      = SAMPLE_BITS;
    localparam int HB      = lr4lp_pkg::HIST_BITS;
    localparam int KB      = lr4lp_pkg::COEF_BITS;
    localparam int FRAC    = lr4lp_pkg::COEF_FRAC;
    localparam int AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int NSUM_W  = SB + 4;
    localparam int OPW     = (NSUM_W > HB) ? NSUM_W : HB;
    localparam int PROD_W  = KB + OPW;
    localparam int ACC_W   = PROD_W + 3;
    localparam int RND_W   = ACC_W - FRAC;
    localparam int RAM_W   = 4 * SB + 4 * HB;
    localparam int CARRY_W = 4 * SB + 3 * HB;
    localparam int DEPTH   = lr4lp_pkg::OUT_DEPTH;
    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;

    localparam logic signed [ACC_W-1:0] ROUND_HALF =
        {{(ACC_W-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};
    localparam logic signed [RND_W-1:0] HIST_MAX = {{(RND_W-HB+1){1'b0}}, {(HB-1){1'b1}}};
    localparam logic signed [RND_W-1:0] HIST_MIN = {{(RND_W-HB+1){1'b1}}, {(HB-1){1'b0}}};
    localparam logic signed [HB-1:0]    SMP_MAX  = {{(HB-SB+1){1'b0}}, {(SB-1){1'b1}}};
    localparam logic signed [HB-1:0]    SMP_MIN  = {{(HB-SB+1){1'b1}}, {(SB-1){1'b0}}};

    // coefficient registers
    logic signed [KB-1:0] gain_reg, b1_reg, b2_reg, b3_reg, b4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= '0;
            b1_reg   <= '0;
            b2_reg   <= '0;
            b3_reg   <= '0;
            b4_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lr4lp_pkg::REG_NUMER_GAIN:    gain_reg <= cfg_data;
                lr4lp_pkg::REG_FB_COEF_ONE:   b1_reg   <= cfg_data;
                lr4lp_pkg::REG_FB_COEF_TWO:   b2_reg   <= cfg_data;
                lr4lp_pkg::REG_FB_COEF_THREE: b3_reg   <= cfg_data;
                lr4lp_pkg::REG_FB_COEF_FOUR:  b4_reg   <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // pipeline control
    logic          v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic [CW-1:0] ch0_reg, ch1_reg, ch2_reg, ch3_reg, ch4_reg;
    logic          oor0_reg, oor1_reg, oor2_reg, oor3_reg, oor4_reg;
    logic          hv0_reg;
    logic [CHANNELS-1:0] valid_reg;

    logic [CNT_W-1:0] fifo_cnt_reg;
    logic [PTR_W-1:0] fifo_wp_reg, fifo_rp_reg;

    logic          [CW-1:0] in_chan;
    logic signed   [SB-1:0] in_smp;
    logic                   in_oor;
    logic          [AW-1:0] in_addr;
    logic                   hazard;
    logic          [SUM_W-1:0] inflight;
    logic                   credit_ok;
    logic                   in_acc;

    assign in_chan = s_axis_tdata[CW-1:0];
    assign in_smp  = s_axis_tdata[CW+SB-1:CW];
    assign in_oor  = (32'(in_chan) >= CHANNELS);
    assign in_addr = AW'(in_chan);

    assign hazard = (v1_reg && (ch1_reg == in_chan)) || (v2_reg && (ch2_reg == in_chan)) ||
                    (v3_reg && (ch3_reg == in_chan)) || (v4_reg && (ch4_reg == in_chan));
    assign inflight = SUM_W'(v1_reg) + SUM_W'(v2_reg) + SUM_W'(v3_reg) + SUM_W'(v4_reg);
    assign credit_ok = (SUM_W'(fifo_cnt_reg) + inflight) < SUM_W'(DEPTH);

    assign s_axis_tready = !v0_reg && !hazard && credit_ok;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // history RAM
    logic [RAM_W-1:0] ram_rdata;
    logic [RAM_W-1:0] ram_wdata;
    logic             ram_we;
    logic [AW-1:0]    wr_addr;

    lr4lp_ram #(
        .WIDTH (RAM_W),
        .DEPTH (CHANNELS)
    ) u_hist_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_addr),
        .wdata (ram_wdata),
        .re    (in_acc),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    // stage 0: history read back, tap sum
    logic signed [SB-1:0] x0_reg;
    logic [RAM_W-1:0]     hist;
    logic signed [SB-1:0] hx1, hx2, hx3, hx4;
    logic signed [HB-1:0] hy1, hy2, hy3, hy4;
    logic signed [NSUM_W-1:0] nsum_next;
    logic [CARRY_W-1:0]   carry_next;

    assign hist = hv0_reg ? ram_rdata : '0;
    assign hx1  = hist[SB-1:0];
    assign hx2  = hist[2*SB-1:SB];
    assign hx3  = hist[3*SB-1:2*SB];
    assign hx4  = hist[4*SB-1:3*SB];
    assign hy1  = hist[4*SB+HB-1:4*SB];
    assign hy2  = hist[4*SB+2*HB-1:4*SB+HB];
    assign hy3  = hist[4*SB+3*HB-1:4*SB+2*HB];
    assign hy4  = hist[4*SB+4*HB-1:4*SB+3*HB];

    assign nsum_next = NSUM_W'(x0_reg) + NSUM_W'(hx4)
                     + (NSUM_W'(hx1) <<< 2) + (NSUM_W'(hx3) <<< 2)
                     + (NSUM_W'(hx2) <<< 2) + (NSUM_W'(hx2) <<< 1);
    assign carry_next = {hy3, hy2, hy1, hx3, hx2, hx1, x0_reg};

    // stage 1..4 payload
    logic signed [NSUM_W-1:0] nsum1_reg;
    logic signed [HB-1:0]     y4_1_reg, y3_2_reg, y4_2_reg;
    logic [CARRY_W-1:0]       carry1_reg, carry2_reg, carry3_reg, carry4_reg;
    logic signed [PROD_W-1:0] p0_2_reg, p1_2_reg, p2_2_reg, q3_3_reg, q4_3_reg;
    logic signed [ACC_W-1:0]  part3_reg, acc4_reg;

    logic signed [HB-1:0] y1_1, y2_1;
    assign y1_1 = carry1_reg[4*SB+HB-1:4*SB];
    assign y2_1 = carry1_reg[4*SB+2*HB-1:4*SB+HB];

    // shared multipliers: first pass in stage 1, second pass in stage 2
    logic signed [KB-1:0]     ma_a, mb_a;
    logic signed [OPW-1:0]    ma_b, mb_b;
    logic signed [PROD_W-1:0] prod_a, prod_b, prod_c;

    assign ma_a = v2_reg ? b3_reg : gain_reg;
    assign ma_b = v2_reg ? OPW'(y3_2_reg) : OPW'(nsum1_reg);
    assign mb_a = v2_reg ? b4_reg : b1_reg;
    assign mb_b = v2_reg ? OPW'(y4_2_reg) : OPW'(y1_1);

    assign prod_a = ma_a * ma_b;
    assign prod_b = mb_a * mb_b;
    assign prod_c = b2_reg * OPW'(y2_1);

    logic signed [ACC_W-1:0] part_next, acc_next;
    assign part_next = ACC_W'(p0_2_reg) - ACC_W'(p1_2_reg) - ACC_W'(p2_2_reg);
    assign acc_next  = part3_reg - ACC_W'(q3_3_reg) - ACC_W'(q4_3_reg) + ROUND_HALF;

    // stage 4: round, saturate, write back
    logic signed [RND_W-1:0] y_rnd;
    logic signed [HB-1:0]    yh_next;
    logic signed [HB-1:0]    ys_sat;
    logic signed [SB-1:0]    smp_next;

    assign y_rnd = acc4_reg[ACC_W-1:FRAC];

    always_comb
    begin
        if (y_rnd > HIST_MAX)
        begin
            yh_next = HIST_MAX[HB-1:0];
        end
        else if (y_rnd < HIST_MIN)
        begin
            yh_next = HIST_MIN[HB-1:0];
        end
        else
        begin
            yh_next = y_rnd[HB-1:0];
        end

        if (yh_next > SMP_MAX)
        begin
            ys_sat = SMP_MAX;
        end
        else if (yh_next < SMP_MIN)
        begin
            ys_sat = SMP_MIN;
        end
        else
        begin
            ys_sat = yh_next;
        end

        smp_next = oor4_reg ? '0 : ys_sat[SB-1:0];
    end

    assign ram_we    = v4_reg && !oor4_reg;
    assign wr_addr   = AW'(ch4_reg);
    assign ram_wdata = {carry4_reg[CARRY_W-1:4*SB], yh_next, carry4_reg[4*SB-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            valid_reg <= '0;
        end
        else
        begin
            v0_reg <= in_acc;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (ram_we)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            ch0_reg  <= in_chan;
            x0_reg   <= in_smp;
            oor0_reg <= in_oor;
            hv0_reg  <= !in_oor && valid_reg[in_addr];
        end
        if (v0_reg)
        begin
            ch1_reg    <= ch0_reg;
            oor1_reg   <= oor0_reg;
            nsum1_reg  <= nsum_next;
            y4_1_reg   <= hy4;
            carry1_reg <= carry_next;
        end
        if (v1_reg)
        begin
            ch2_reg    <= ch1_reg;
            oor2_reg   <= oor1_reg;
            p0_2_reg   <= prod_a;
            p1_2_reg   <= prod_b;
            p2_2_reg   <= prod_c;
            y3_2_reg   <= carry1_reg[4*SB+3*HB-1:4*SB+2*HB];
            y4_2_reg   <= y4_1_reg;
            carry2_reg <= carry1_reg;
        end
        if (v2_reg)
        begin
            ch3_reg    <= ch2_reg;
            oor3_reg   <= oor2_reg;
            part3_reg  <= part_next;
            q3_3_reg   <= prod_a;
            q4_3_reg   <= prod_b;
            carry3_reg <= carry2_reg;
        end
        if (v3_reg)
        begin
            ch4_reg    <= ch3_reg;
            oor4_reg   <= oor3_reg;
            acc4_reg   <= acc_next;
            carry4_reg <= carry3_reg;
        end
    end

    // output queue
    logic [CW-1:0]        fifo_ch_reg  [DEPTH];
    logic signed [SB-1:0] fifo_smp_reg [DEPTH];
    logic                 pop;
    logic [CNT_W-1:0]     fifo_cnt_next;

    assign pop = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        fifo_cnt_next = fifo_cnt_reg;
        if (v4_reg && !pop)
        begin
            fifo_cnt_next = fifo_cnt_reg + CNT_W'(1);
        end
        else if (!v4_reg && pop)
        begin
            fifo_cnt_next = fifo_cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fifo_cnt_reg <= '0;
            fifo_wp_reg  <= '0;
            fifo_rp_reg  <= '0;
        end
        else
        begin
            fifo_cnt_reg <= fifo_cnt_next;
            if (v4_reg)
            begin
                fifo_wp_reg <= fifo_wp_reg + PTR_W'(1);
            end
            if (pop)
            begin
                fifo_rp_reg <= fifo_rp_reg + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (v4_reg)
        begin
            fifo_ch_reg[fifo_wp_reg]  <= ch4_reg;
            fifo_smp_reg[fifo_wp_reg] <= smp_next;
        end
    end

    assign m_axis_tvalid = (fifo_cnt_reg != '0);
    assign m_axis_tdata  = TDATA_BITS'({fifo_smp_reg[fifo_rp_reg], fifo_ch_reg[fifo_rp_reg]});

`ifndef SYNTHESIS
    a_mult_share: assert property (@(posedge clk) disable iff (!rst_n)
        !(v1_reg && v2_reg))
        else $error("shared multipliers claimed by two stages");

    a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fifo_cnt_reg <= CNT_W'(DEPTH))
        else $error("output queue overfilled");

    a_credit: assert property (@(posedge clk) disable iff (!rst_n)
        (SUM_W'(fifo_cnt_reg) + inflight + SUM_W'(v0_reg)) <= SUM_W'(DEPTH))
        else $error("more words committed than the output queue holds");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && v4_reg |-> ch4_reg != in_chan)
        else $error("history read while same channel write back pending");

    a_wb_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> valid_reg[$past(wr_addr)])
        else $error("written history entry not marked valid");
`endif

endmodule
